// ===== rtl/acfc_pkg.sv =====
// ============================================================================
// acfc_pkg : shared types and constants of the ASCII command frame checker
// Status codes, ASCII constants, per-frame data record, result record and the
// decimal digit expansion used for the checksum compare.
// ============================================================================
package acfc_pkg;

   // frame status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_CHECKSUM = 3'd1;
   localparam logic [2:0] STATUS_UNKNOWN  = 3'd2;
   localparam logic [2:0] STATUS_SENSOR   = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

   // configuration register indexes
   localparam logic CSR_START_SYMBOL = 1'b0;
   localparam logic CSR_END_SYMBOL   = 1'b1;

   localparam logic [7:0] START_SYMBOL_RESET = 8'd35;
   localparam logic [7:0] END_SYMBOL_RESET   = 8'd33;

   // ASCII characters
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_P    = 8'h50;
   localparam logic [7:0] CHAR_T    = 8'h74;
   localparam logic [7:0] CHAR_H    = 8'h68;
   localparam logic [7:0] CHAR_C    = 8'h63;

   // bytes collected for the frame under way
   typedef struct packed {
      logic [7:0] settled_sum;
      logic [7:0] recent0;   // oldest of the last three bytes
      logic [7:0] recent1;
      logic [7:0] recent2;   // newest
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } frame_data_type;

   // one result beat
   typedef struct packed {
      logic [2:0] frame_status;
      logic [7:0] command_byte;
      logic [7:0] sensor_byte;
      logic [7:0] computed_sum;
      logic [6:0] payload_length;
   } result_type;

   // Expand a byte into three zero-padded ASCII decimal digits, hundreds first.
   // Tens come from a multiply by 205 and shift by 11, exact below 160.
   function automatic logic [23:0] ascii_digits(input logic [7:0] value);
      logic [1:0]  hundreds;
      logic [7:0]  rem;
      logic [14:0] scaled;
      logic [3:0]  tens;
      logic [3:0]  ones;
      if (value >= 8'd200) begin
         hundreds = 2'd2;
      end else if (value >= 8'd100) begin
         hundreds = 2'd1;
      end else begin
         hundreds = 2'd0;
      end
      rem    = value - 8'(hundreds) * 8'd100;
      scaled = 15'(rem) * 15'd205;
      tens   = scaled[14:11];
      ones   = 4'(rem - 8'(tens) * 8'd10);
      return {CHAR_ZERO + 8'(hundreds), CHAR_ZERO + 8'(tens), CHAR_ZERO + 8'(ones)};
   endfunction

endpackage

// ===== rtl/acfc_frame_step.sv =====
// ============================================================================
// acfc_frame_step : next-state and result logic for one received byte
// Hunts for the start symbol, collects bytes, checks the checksum digits and
// the command at the end symbol, and flags frames that grow past the limit.
// ============================================================================
module acfc_frame_step #(
   parameter int MAX_FRAME = 64
) (
   input  logic                          byte_valid,
   input  logic [7:0]                    rx_byte,
   input  logic [7:0]                    start_symbol,
   input  logic [7:0]                    end_symbol,
   input  logic                          in_frame,
   input  logic [$clog2(MAX_FRAME)-1:0]  frame_count,
   input  acfc_pkg::frame_data_type      frame_data,
   output logic                          in_frame_in,
   output logic [$clog2(MAX_FRAME)-1:0]  frame_count_in,
   output acfc_pkg::frame_data_type      frame_data_in,
   output logic                          result_fire,
   output acfc_pkg::result_type          result
);

   localparam int CNT_W = $clog2(MAX_FRAME);
   localparam int LEN_W = (CNT_W > 7) ? CNT_W : 7;
   localparam logic [CNT_W:0] OVF_COUNT = (CNT_W + 1)'(MAX_FRAME - 2);

   logic [23:0]      digits;
   logic             short_frame;
   logic [LEN_W-1:0] len_wide;
   logic [6:0]       len_sat;
   logic [2:0]       end_status;
   logic             overflow;

   assign digits      = acfc_pkg::ascii_digits(frame_data.settled_sum);
   assign short_frame = frame_count < CNT_W'(3);
   assign len_wide    = LEN_W'(frame_count) - LEN_W'(3);
   assign len_sat     = (len_wide > LEN_W'(127)) ? 7'd127 : len_wide[6:0];
   assign overflow    = {1'b0, frame_count} >= OVF_COUNT;

   always_comb begin
      priority if (short_frame) begin
         end_status = acfc_pkg::STATUS_CHECKSUM;
      end else if ({frame_data.recent0, frame_data.recent1, frame_data.recent2} != digits) begin
         end_status = acfc_pkg::STATUS_CHECKSUM;
      end else if (frame_data.first_byte == acfc_pkg::CHAR_A) begin
         end_status = acfc_pkg::STATUS_OK;
      end else if (frame_data.first_byte == acfc_pkg::CHAR_P) begin
         end_status = (frame_data.second_byte == acfc_pkg::CHAR_T ||
                       frame_data.second_byte == acfc_pkg::CHAR_H ||
                       frame_data.second_byte == acfc_pkg::CHAR_C)
                      ? acfc_pkg::STATUS_OK : acfc_pkg::STATUS_SENSOR;
      end else begin
         end_status = acfc_pkg::STATUS_UNKNOWN;
      end
   end

   always_comb begin
      in_frame_in    = in_frame;
      frame_count_in = frame_count;
      frame_data_in  = frame_data;
      result_fire    = 1'b0;
      result.frame_status   = end_status;
      result.command_byte   = frame_data.first_byte;
      result.sensor_byte    = frame_data.second_byte;
      result.computed_sum   = short_frame ? 8'd0 : frame_data.settled_sum;
      result.payload_length = short_frame ? 7'd0 : len_sat;

      if (byte_valid) begin
         priority if (!in_frame) begin
            if (rx_byte == start_symbol) begin
               in_frame_in    = 1'b1;
               frame_count_in = '0;
               frame_data_in  = '0;
            end
         end else if (rx_byte == end_symbol) begin
            in_frame_in = 1'b0;
            result_fire = 1'b1;
         end else if (overflow) begin
            // drop the byte and report the oversized frame
            in_frame_in           = 1'b0;
            result_fire           = 1'b1;
            result.frame_status   = acfc_pkg::STATUS_OVERFLOW;
            result.computed_sum   = 8'd0;
            result.payload_length = 7'd0;
         end else begin
            if (frame_count == CNT_W'(0)) begin
               frame_data_in.first_byte = rx_byte;
            end
            if (frame_count == CNT_W'(1)) begin
               frame_data_in.second_byte = rx_byte;
            end
            if (!short_frame) begin
               frame_data_in.settled_sum = frame_data.settled_sum + frame_data.recent0;
            end
            frame_data_in.recent0 = frame_data.recent1;
            frame_data_in.recent1 = frame_data.recent2;
            frame_data_in.recent2 = rx_byte;
            frame_count_in        = frame_count + CNT_W'(1);
         end
      end
   end

endmodule

// ===== rtl/ascii_command_frame_checker_unit.sv =====
// ============================================================================
// ascii_command_frame_checker_unit : ASCII command frame checker
// Checks start/end delimited command frames carried one byte per beat and
// returns one status beat per frame, with command, sensor byte and checksum.
// ============================================================================
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   req_     | in        | req_valid/req_stall | req_rx_byte
//   rsp_     | out       | rsp_valid/rsp_stall | status, command, sensor, sum,
//            |           |                     | payload length
//   csr_     | in        | csr_write           | csr_index, csr_wdata
//
// One byte beat is taken every cycle while req_stall is low. A result beat is
// formed from the frame state registers as the end symbol (or the overflowing
// byte) is taken and lands in the output register, or in the skid register.
// A skid register behind the output register keeps req_ flowing while a result
// waits; req_stall rises only while both hold a result.
// Reset (synchronous, active high) restores the default symbols '#' and '!',
// sets the checker hunting and empties the output side.
// ============================================================================
module ascii_command_frame_checker_unit #(
   parameter int MAX_FRAME = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_frame_status,
   output logic [7:0] rsp_command_byte,
   output logic [7:0] rsp_sensor_byte,
   output logic [7:0] rsp_computed_sum,
   output logic [6:0] rsp_payload_length,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_FRAME);

   // configuration
   logic [7:0] start_symbol_ff;
   logic [7:0] end_symbol_ff;

   // frame state
   logic                     in_frame_ff;
   logic                     in_frame_in;
   logic [CNT_W-1:0]         frame_count_ff;
   logic [CNT_W-1:0]         frame_count_in;
   acfc_pkg::frame_data_type frame_data_ff;
   acfc_pkg::frame_data_type frame_data_in;

   // result path
   logic                 result_fire;
   acfc_pkg::result_type result;
   logic                 rsp_valid_ff;
   acfc_pkg::result_type rsp_data_ff;
   logic                 skid_valid_ff;
   acfc_pkg::result_type skid_data_ff;
   logic                 req_accept;
   logic                 out_free;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_symbol_ff <= acfc_pkg::START_SYMBOL_RESET;
         end_symbol_ff   <= acfc_pkg::END_SYMBOL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            acfc_pkg::CSR_START_SYMBOL: start_symbol_ff <= csr_wdata;
            acfc_pkg::CSR_END_SYMBOL:   end_symbol_ff   <= csr_wdata;
         endcase
      end
   end

   acfc_frame_step #(
      .MAX_FRAME (MAX_FRAME)
   ) u_step (
      .byte_valid     (req_accept),
      .rx_byte        (req_rx_byte),
      .start_symbol   (start_symbol_ff),
      .end_symbol     (end_symbol_ff),
      .in_frame       (in_frame_ff),
      .frame_count    (frame_count_ff),
      .frame_data     (frame_data_ff),
      .in_frame_in    (in_frame_in),
      .frame_count_in (frame_count_in),
      .frame_data_in  (frame_data_in),
      .result_fire    (result_fire),
      .result         (result)
   );

   // frame state: advance on every accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         frame_count_ff <= '0;
         frame_data_ff  <= '0;
      end else begin
         in_frame_ff    <= in_frame_in;
         frame_count_ff <= frame_count_in;
         frame_data_ff  <= frame_data_in;
      end
   end

   // output register with skid: a new result lands in the output register when
   // it is free, otherwise in the skid register; the skid drains first.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= result_fire;
            end
         end else if (result_fire) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end
      if (!out_free && result_fire) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_status   = rsp_data_ff.frame_status;
   assign rsp_command_byte   = rsp_data_ff.command_byte;
   assign rsp_sensor_byte    = rsp_data_ff.sensor_byte;
   assign rsp_computed_sum   = rsp_data_ff.computed_sum;
   assign rsp_payload_length = rsp_data_ff.payload_length;

   // skid holds a result only behind a held output result
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // frame never grows past the overflow point
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, frame_count_ff} <= (CNT_W + 1)'(MAX_FRAME - 2))
      else $error("frame count beyond limit");

   // overflow results carry no sum and no length
   a_overflow_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_status == acfc_pkg::STATUS_OVERFLOW
      |-> rsp_data_ff.computed_sum == 8'd0 && rsp_data_ff.payload_length == 7'd0)
      else $error("overflow result with sum or length");

   // a passing frame carries a known command
   a_ok_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_status == acfc_pkg::STATUS_OK
      |-> rsp_data_ff.command_byte == acfc_pkg::CHAR_A ||
          rsp_data_ff.command_byte == acfc_pkg::CHAR_P)
      else $error("ok status with unknown command");

   // a result is produced only while a frame is open
   a_result_in_frame: assert property (@(posedge clock) disable iff (reset)
      result_fire |-> in_frame_ff && !in_frame_in)
      else $error("result outside an open frame");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top : self-checking bench for the ASCII command frame checker
// Streams start/end delimited frames and line noise into the byte channel,
// tracks the expected status beat of every frame in a small scoreboard and
// compares each result beat field by field, over several symbol settings and
// several sender/receiver idle patterns.
// ============================================================================

localparam int FRAME_LIMIT = 64;

// Tracks the frame state of the checker and holds the status beats still owed.
class frame_tracker;
   logic [7:0]           start_sym;
   logic [7:0]           end_sym;
   bit                   in_frame;
   int unsigned          byte_count;
   logic [7:0]           payload_sum;
   logic [7:0]           tail [3];
   logic [7:0]           cmd_byte;
   logic [7:0]           sensor_id;
   acfc_pkg::result_type awaited_results [$];
   int unsigned          errors;

   function new();
      start_sym = acfc_pkg::START_SYMBOL_RESET;
      end_sym   = acfc_pkg::END_SYMBOL_RESET;
      in_frame  = 1'b0;
      errors    = 0;
      clear_frame();
   endfunction

   function void clear_frame();
      byte_count  = 0;
      payload_sum = '0;
      tail        = '{default: '0};
      cmd_byte    = '0;
      sensor_id   = '0;
   endfunction

   function void write_symbol(logic idx, logic [7:0] value);
      if (idx == acfc_pkg::CSR_START_SYMBOL) start_sym = value;
      else end_sym = value;
   endfunction

   // Advance the frame state by one accepted byte beat.
   function void take_byte(logic [7:0] b);
      acfc_pkg::result_type res;
      bit                   digits_ok;
      if (!in_frame) begin
         if (b == start_sym) begin
            in_frame = 1'b1;
            clear_frame();
         end
         return;
      end
      res              = '0;
      res.command_byte = cmd_byte;
      res.sensor_byte  = sensor_id;
      if (b == end_sym) begin
         if (byte_count < 3) begin
            res.frame_status = acfc_pkg::STATUS_CHECKSUM;
         end else begin
            res.computed_sum   = payload_sum;
            res.payload_length = (byte_count > 130) ? 7'd127 : 7'(byte_count - 3);
            digits_ok = tail[0] == 8'(acfc_pkg::CHAR_ZERO + payload_sum / 100) &&
                        tail[1] == 8'(acfc_pkg::CHAR_ZERO + (payload_sum / 10) % 10) &&
                        tail[2] == 8'(acfc_pkg::CHAR_ZERO + payload_sum % 10);
            if (!digits_ok) res.frame_status = acfc_pkg::STATUS_CHECKSUM;
            else if (cmd_byte == acfc_pkg::CHAR_A) res.frame_status = acfc_pkg::STATUS_OK;
            else if (cmd_byte == acfc_pkg::CHAR_P)
               res.frame_status = (sensor_id == acfc_pkg::CHAR_T ||
                                   sensor_id == acfc_pkg::CHAR_H ||
                                   sensor_id == acfc_pkg::CHAR_C)
                                  ? acfc_pkg::STATUS_OK : acfc_pkg::STATUS_SENSOR;
            else res.frame_status = acfc_pkg::STATUS_UNKNOWN;
         end
         awaited_results.push_back(res);
         in_frame = 1'b0;
         return;
      end
      if (byte_count + 2 >= FRAME_LIMIT) begin
         res.frame_status = acfc_pkg::STATUS_OVERFLOW;
         awaited_results.push_back(res);
         in_frame = 1'b0;
         return;
      end
      if (byte_count == 0) cmd_byte = b;
      else if (byte_count == 1) sensor_id = b;
      // the oldest tail byte can no longer be a checksum digit
      if (byte_count >= 3) payload_sum = payload_sum + tail[0];
      tail[0] = tail[1];
      tail[1] = tail[2];
      tail[2] = b;
      byte_count++;
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   function void compare_result(acfc_pkg::result_type got);
      acfc_pkg::result_type want;
      if (awaited_results.size() == 0) begin
         $error("result beat with no frame outstanding (frame_status %0d)",
                got.frame_status);
         errors++;
         return;
      end
      want = awaited_results.pop_front();
      compare_field("frame_status", 8'(want.frame_status), 8'(got.frame_status));
      compare_field("command_byte", want.command_byte, got.command_byte);
      compare_field("sensor_byte", want.sensor_byte, got.sensor_byte);
      compare_field("computed_sum", want.computed_sum, got.computed_sum);
      compare_field("payload_length", 8'(want.payload_length), 8'(got.payload_length));
   endfunction
endclass

module tb_top;

   typedef enum int {
      FRAME_GOOD_A,
      FRAME_GOOD_P,
      FRAME_BAD_SENSOR,
      FRAME_UNKNOWN,
      FRAME_BAD_SUM,
      FRAME_SHORT,
      FRAME_OVERFLOW,
      FRAME_NOISE
   } frame_kind_type;

   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_BYTES  = 240;
   localparam int unsigned SETTLE_CYCLES = 4;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [2:0] rsp_frame_status;
   logic [7:0] rsp_command_byte;
   logic [7:0] rsp_sensor_byte;
   logic [7:0] rsp_computed_sum;
   logic [6:0] rsp_payload_length;
   logic       csr_write   = 1'b0;
   logic       csr_index   = acfc_pkg::CSR_START_SYMBOL;
   logic [7:0] csr_wdata   = '0;

   // idle rates in percent, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   frame_tracker frames = new();
   logic [7:0]   frame_bytes [$];

   ascii_command_frame_checker_unit #(
      .MAX_FRAME(FRAME_LIMIT)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_command_byte   (rsp_command_byte),
      .rsp_sensor_byte    (rsp_sensor_byte),
      .rsp_computed_sum   (rsp_computed_sum),
      .rsp_payload_length (rsp_payload_length),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver side: stall at the phase rate, decided once per edge.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Result monitor: a beat moves at an edge with valid high and stall low.
   // Values read here are the ones present just before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         frames.compare_result({rsp_frame_status, rsp_command_byte, rsp_sensor_byte,
                                rsp_computed_sum, rsp_payload_length});
      end
   end

   // Drive one byte beat and hold it until the checker takes it. Valid is left
   // high on return so a back-to-back beat needs no second assignment.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames.take_byte(b);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   // Drop valid and hold off until every owed result beat has arrived.
   task automatic wait_for_results(input int unsigned settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames.awaited_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_symbols(input logic [7:0] start_value, input logic [7:0] end_value);
      csr_write <= 1'b1;
      csr_index <= acfc_pkg::CSR_START_SYMBOL;
      csr_wdata <= start_value;
      @(posedge clock);
      frames.write_symbol(acfc_pkg::CSR_START_SYMBOL, start_value);
      csr_index <= acfc_pkg::CSR_END_SYMBOL;
      csr_wdata <= end_value;
      @(posedge clock);
      frames.write_symbol(acfc_pkg::CSR_END_SYMBOL, end_value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Any byte except the end symbol, so the frame keeps going.
   function automatic logic [7:0] data_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == frames.end_sym);
      return b;
   endfunction

   function automatic frame_kind_type pick_kind();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 25) return FRAME_GOOD_A;
      if (r < 45) return FRAME_GOOD_P;
      if (r < 55) return FRAME_BAD_SENSOR;
      if (r < 65) return FRAME_UNKNOWN;
      if (r < 77) return FRAME_BAD_SUM;
      if (r < 85) return FRAME_SHORT;
      if (r < 88) return FRAME_OVERFLOW;
      return FRAME_NOISE;
   endfunction

   // Fill frame_bytes with one frame of the given kind under the current symbols.
   function automatic void build_frame(frame_kind_type kind);
      int unsigned body_len;
      int unsigned slot;
      logic [7:0]  body [$];
      logic [7:0]  sum;
      logic [7:0]  digits [3];
      logic [7:0]  wrong;
      frame_bytes.delete();
      if (kind == FRAME_NOISE) begin
         // stray bytes while hunting; a start symbol among them opens a frame
         repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom_range(255)));
         return;
      end
      frame_bytes.push_back(frames.start_sym);
      case (kind)
         FRAME_SHORT:    body_len = $urandom_range(2);
         FRAME_OVERFLOW: body_len = $urandom_range(FRAME_LIMIT + 6, FRAME_LIMIT - 1);
         default: begin
            // mostly short payloads, now and then up to the longest that fits
            body_len = ($urandom_range(9) == 0) ? $urandom_range(FRAME_LIMIT - 5)
                                                 : $urandom_range(8);
         end
      endcase
      if (kind == FRAME_GOOD_A && body_len < 1) body_len = 1;
      if ((kind == FRAME_GOOD_P || kind == FRAME_BAD_SENSOR) && body_len < 2) body_len = 2;
      repeat (body_len) body.push_back(data_byte());
      case (kind)
         FRAME_GOOD_A: body[0] = acfc_pkg::CHAR_A;
         FRAME_GOOD_P: begin
            body[0] = acfc_pkg::CHAR_P;
            case ($urandom_range(2))
               0:       body[1] = acfc_pkg::CHAR_T;
               1:       body[1] = acfc_pkg::CHAR_H;
               default: body[1] = acfc_pkg::CHAR_C;
            endcase
         end
         FRAME_BAD_SENSOR: body[0] = acfc_pkg::CHAR_P;
         FRAME_BAD_SUM: if (body_len > 0 && $urandom_range(1) == 0) body[0] = acfc_pkg::CHAR_A;
         default: ;
      endcase
      // a start symbol inside the frame is plain data
      if (body_len > 2 && $urandom_range(7) == 0 && frames.start_sym != frames.end_sym) begin
         body[$urandom_range(body_len - 1, 2)] = frames.start_sym;
      end
      foreach (body[i]) frame_bytes.push_back(body[i]);
      if (kind != FRAME_SHORT && kind != FRAME_OVERFLOW) begin
         sum = '0;
         foreach (body[i]) sum = sum + body[i];
         digits[0] = 8'(acfc_pkg::CHAR_ZERO + sum / 100);
         digits[1] = 8'(acfc_pkg::CHAR_ZERO + (sum / 10) % 10);
         digits[2] = 8'(acfc_pkg::CHAR_ZERO + sum % 10);
         if (kind == FRAME_BAD_SUM) begin
            slot = $urandom_range(2);
            do wrong = data_byte(); while (wrong == digits[slot]);
            digits[slot] = wrong;
         end
         foreach (digits[i]) frame_bytes.push_back(digits[i]);
      end
      frame_bytes.push_back(frames.end_sym);
   endfunction

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   // Hard stop in case the checker hangs.
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int unsigned sent;
      logic [7:0]  sym;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset symbols: noise at both byte extremes,
      // an empty frame, a frame too short for digits, a good 'A' frame, a good
      // 'P' frame and a start symbol used as payload.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("#!");
      send_text("#A0!");
      send_text("#A065!");
      send_text("#Pt196!");
      send_text("#A#100!");

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         // symbols change only with nothing in flight
         wait_for_results(SETTLE_CYCLES);
         sym = 8'($urandom_range(255));
         case (phase)
            0:       set_symbols(acfc_pkg::START_SYMBOL_RESET, acfc_pkg::END_SYMBOL_RESET);
            1:       set_symbols(8'h00, 8'hFF);
            2:       set_symbols(8'hFF, 8'h00);
            3:       set_symbols(8'h24, 8'h24);  // one symbol opens and closes
            4:       set_symbols(8'($urandom_range(255)), 8'($urandom_range(255)));
            5:       set_symbols(sym, sym);
            6:       set_symbols(8'($urandom_range(255)), 8'($urandom_range(255)));
            default: set_symbols(acfc_pkg::START_SYMBOL_RESET, acfc_pkg::END_SYMBOL_RESET);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase

         sent = 0;
         // open some phases with a frame that runs past the limit
         if (phase % 4 == 1) begin
            build_frame(FRAME_OVERFLOW);
            send_frame();
            sent += frame_bytes.size();
         end
         while (sent < PHASE_BYTES) begin
            build_frame(pick_kind());
            send_frame();
            sent += frame_bytes.size();
            // now and then hold the sender until the result side is empty
            if ($urandom_range(24) == 0) wait_for_results(0);
         end
      end

      wait_for_results(2 * SETTLE_CYCLES);
      if (frames.errors == 0 && frames.awaited_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
